// File: src/cfba_pkg.sv
// Shared constants and types for the chunked fixed block allocator.
package cfba_pkg;

    localparam int MAX_CHUNKS = 16;
    localparam int CHUNK_W    = 4;
    localparam int POS_W      = 5;
    localparam int BLK_W      = 8;
    localparam int FREE_W     = 12;
    localparam int LINK_AW    = CHUNK_W + BLK_W;

    localparam logic [BLK_W-1:0] MAX_BLOCKS = 8'd255;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_REL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALC_CHK,
        S_SEARCH,
        S_OPEN,
        S_FILL,
        S_GRANT_RD,
        S_GRANT_WR,
        S_REL_CHK,
        S_REL_SEARCH,
        S_REL_UPD,
        S_DONE
    } t_state;

endpackage

// File: src/cfba_link_ram.sv
// Single-port-write, single-port-read link memory with registered read data.
module cfba_link_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/chunked_fixed_block_allocator.sv
// Top level of the chunked fixed block allocator.
// Each input word is one request: tuser[0] selects allocate or release, and for a
// release tdata names the chunk slot and block. Every request returns one result
// word with a status and, for a successful allocate, the granted slot and block.
// Requests are handled one at a time. An allocate from the current chunk is checked,
// then reads the link memory and updates the head; a chunk search scans the list
// positions in order (up to 16), and opening a chunk writes one link entry per cycle,
// blocks_per_chunk entries. A release scans the list positions to find its chunk.
// The link memory has one write and one read port with registered read data; the
// free list heads and counts sit in registers. A finished result waits in the
// output register while the next request is accepted.
module chunked_fixed_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: blocks_per_chunk
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [3:0] release_chunk, [11:4] release_block, zero pad
    input  logic [0:0]  i_s_axis_tuser,  // [0] operation
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // [1:0] status, [5:2] granted_chunk,
                                         // [13:6] granted_block, zero pad
);
    import cfba_pkg::*;

    t_state r_state, n_state;

    logic [BLK_W-1:0]   r_cfg;
    logic [CHUNK_W-1:0] r_rchunk;
    logic [BLK_W-1:0]   r_rblk;
    logic [POS_W-1:0]   r_live;
    logic [CHUNK_W-1:0] r_order [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] r_busy;
    logic [BLK_W-1:0]   r_head  [MAX_CHUNKS];
    logic [BLK_W-1:0]   r_avail [MAX_CHUNKS];
    logic [POS_W-1:0]   r_apos, r_rpos, r_ipos, r_p;
    logic               r_imark;
    logic [FREE_W-1:0]  r_ftot;
    logic [BLK_W-1:0]   r_fill;
    logic [CHUNK_W-1:0] r_slot;
    logic [1:0]         r_res_status;
    logic [CHUNK_W-1:0] r_res_chunk;
    logic [BLK_W-1:0]   r_res_blk;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [CHUNK_W-1:0] r_out_chunk;
    logic [BLK_W-1:0]   r_out_blk;

    logic [BLK_W-1:0]   eff;
    logic [CHUNK_W-1:0] a_slot, p_slot, free_slot, last_idx;
    logic               free_found;
    logic               alc_ready;
    logic [BLK_W-1:0]   rel_cnt;
    logic               mem_we;
    logic [LINK_AW-1:0] mem_waddr, mem_raddr;
    logic [BLK_W-1:0]   mem_wdata, mem_rdata;
    logic [POS_W-1:0]   live_dec;

    // effective block count
    assign eff = (r_cfg == '0) ? BLK_W'(1) : r_cfg;

    assign a_slot   = r_order[r_apos[CHUNK_W-1:0]];
    assign p_slot   = r_order[r_p[CHUNK_W-1:0]];
    assign live_dec = r_live - POS_W'(1);
    assign last_idx = live_dec[CHUNK_W-1:0];
    assign rel_cnt  = r_avail[r_rchunk] + BLK_W'(1);

    assign alc_ready = (r_ftot != '0) && (r_apos < r_live) && (r_avail[a_slot] != '0);

    // lowest clear slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = MAX_CHUNKS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                free_found = 1'b1;
                free_slot  = CHUNK_W'(s);
            end
        end
    end

    // link memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_slot, r_fill};
        mem_wdata = r_fill + BLK_W'(1);
        if (r_state == S_FILL) begin
            mem_we = 1'b1;
        end else if (r_state == S_REL_UPD) begin
            mem_we    = 1'b1;
            mem_waddr = {r_rchunk, r_rblk};
            mem_wdata = r_head[r_rchunk];
        end
    end
    assign mem_raddr = {a_slot, r_head[a_slot]};

    cfba_link_ram #(
        .ADDR_W (LINK_AW),
        .DATA_W (BLK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = (i_s_axis_tuser[0] == OP_RELEASE) ? S_REL_CHK : S_ALC_CHK;
                end
            end
            S_ALC_CHK: begin
                if (alc_ready)           n_state = S_GRANT_RD;
                else if (r_ftot != '0)   n_state = S_SEARCH;
                else                     n_state = S_OPEN;
            end
            S_SEARCH: begin
                if (r_p >= r_live)              n_state = S_OPEN;
                else if (r_avail[p_slot] != '0) n_state = S_GRANT_RD;
            end
            S_OPEN: begin
                if (r_live >= POS_W'(MAX_CHUNKS) || !free_found) n_state = S_DONE;
                else                                              n_state = S_FILL;
            end
            S_FILL: begin
                if (r_fill == eff - BLK_W'(1)) n_state = S_GRANT_RD;
            end
            S_GRANT_RD: n_state = S_GRANT_WR;
            S_GRANT_WR: n_state = S_DONE;
            S_REL_CHK: begin
                if (!r_busy[r_rchunk] || r_rblk >= eff || r_avail[r_rchunk] >= eff)
                    n_state = S_DONE;
                else
                    n_state = S_REL_SEARCH;
            end
            S_REL_SEARCH: begin
                if (r_p >= r_live)          n_state = S_DONE;
                else if (p_slot == r_rchunk) n_state = S_REL_UPD;
            end
            S_REL_UPD: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_m_axis_tvalid = r_out_valid;
        o_m_axis_tdata  = {2'b00, r_out_blk, r_out_chunk, r_out_status};
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= MAX_BLOCKS;
        end else if (i_cfg_wen) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid  <= 1'b1;
            r_out_status <= r_res_status;
            r_out_chunk  <= r_res_chunk;
            r_out_blk    <= r_res_blk;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // allocator state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_busy  <= '0;
            r_apos  <= '0;
            r_rpos  <= '0;
            r_ipos  <= '0;
            r_imark <= 1'b0;
            r_ftot  <= '0;
            r_p     <= '0;
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                r_order[i] <= '0;
                r_head[i]  <= '0;
                r_avail[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_rchunk <= i_s_axis_tdata[3:0];
                    r_rblk   <= i_s_axis_tdata[11:4];
                    r_p      <= '0;
                end
                S_SEARCH: begin
                    if (r_p < r_live) begin
                        if (r_avail[p_slot] != '0) r_apos <= r_p;
                        else                       r_p <= r_p + POS_W'(1);
                    end
                end
                S_OPEN: begin
                    r_res_status <= ST_FULL;
                    r_res_chunk  <= '0;
                    r_res_blk    <= '0;
                    r_slot       <= free_slot;
                    r_fill       <= '0;
                end
                S_FILL: begin
                    r_fill <= r_fill + BLK_W'(1);
                    if (r_fill == eff - BLK_W'(1)) begin
                        r_busy[r_slot]                  <= 1'b1;
                        r_head[r_slot]                  <= '0;
                        r_avail[r_slot]                 <= eff;
                        r_order[r_live[CHUNK_W-1:0]]    <= r_slot;
                        r_apos                          <= r_live;
                        r_rpos                          <= r_live;
                        r_live                          <= r_live + POS_W'(1);
                        r_ftot                          <= r_ftot + FREE_W'(eff);
                    end
                end
                S_GRANT_RD: begin
                    r_slot <= a_slot;
                end
                S_GRANT_WR: begin
                    r_head[r_slot]  <= (r_head[r_slot] == MAX_BLOCKS) ? '0 : mem_rdata;
                    r_avail[r_slot] <= r_avail[r_slot] - BLK_W'(1);
                    r_ftot          <= r_ftot - FREE_W'(1);
                    r_res_status    <= ST_OK;
                    r_res_chunk     <= r_slot;
                    r_res_blk       <= r_head[r_slot];
                end
                S_REL_CHK: begin
                    r_res_status <= ST_BAD_REL;
                    r_res_chunk  <= '0;
                    r_res_blk    <= '0;
                end
                S_REL_SEARCH: begin
                    if (r_p < r_live && p_slot != r_rchunk) r_p <= r_p + POS_W'(1);
                end
                S_REL_UPD: begin
                    r_res_status      <= ST_OK;
                    r_head[r_rchunk]  <= r_rblk;
                    r_avail[r_rchunk] <= rel_cnt;
                    if (rel_cnt == eff && !r_imark) begin
                        // first wholly free chunk is remembered
                        r_imark <= 1'b1;
                        r_ipos  <= r_p;
                        r_rpos  <= r_p;
                        r_ftot  <= r_ftot + FREE_W'(1);
                    end else if (rel_cnt == eff) begin
                        // swap the idle chunk to the end and drop it, unless it is the only live chunk
                        if (r_p[CHUNK_W-1:0] != last_idx) begin
                            r_order[r_p[CHUNK_W-1:0]] <= r_order[last_idx];
                            r_order[last_idx]         <= p_slot;
                        end
                        if (r_live > POS_W'(1)) begin
                            r_busy[r_rchunk] <= 1'b0;
                            r_live           <= live_dec;
                            r_ftot           <= r_ftot - FREE_W'(eff) + FREE_W'(1);
                            r_rpos           <= live_dec >> 1;
                        end else begin
                            r_ftot <= r_ftot + FREE_W'(1);
                            r_rpos <= r_live >> 1;
                        end
                    end else begin
                        r_rpos <= r_p;
                        r_ftot <= r_ftot + FREE_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
